// File: rtl/pcld_pkg.sv
// package for the per-client length-prefix deframer
// types, result kinds and reset values; no dependencies
`default_nettype none
package pcld_pkg;
    localparam int SESSIONS_DEF = 16;
    localparam int MAX_EXPIRE = 16;
    localparam logic [15:0] TIMEOUT_RST = 16'd30;
    localparam logic [15:0] INTERVAL_RST = 16'd10;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_byte;   // process byte beat in datapath
        logic take_tick;   // advance time and interval count
        logic scan_start;  // clear scan index
        logic scan_step;   // examine one slot
        logic flush;       // send held expiry as final beat
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_due;    // tick beat would start a scan
        logic scan_done;   // scan index at the last slot
    } t_status;
endpackage
`default_nettype wire

// File: rtl/per_client_length_prefix_deframer_unit.sv
// deframer top: one byte beat per cycle through a parallel slot match,
// result registered and valid the cycle after the beat; a held result blocks input
// a tick that starts a scan blocks input while the SCAN state steps one slot per cycle
// and the FLUSH state then sends the final expiry; both hold while results stall
// reset (synchronous, active low) frees all sessions, time and counters zero
// depends on pcld_pkg, pcld_ctrl, pcld_dp
`default_nettype none
module per_client_length_prefix_deframer_unit #(
    parameter int SESSIONS = pcld_pkg::SESSIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // client_ip, client_port, data_byte
    input  wire logic        s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // session_slot, payload_byte, message_end,
                                            // cut_short, pad
    output logic [1:0]       m_axis_tuser,  // result_kind
    output logic             m_axis_tlast,  // last_of_run
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    pcld_pkg::t_cmd w_cmd;
    pcld_pkg::t_status w_status;
    logic w_free, w_cut, w_end;
    logic [3:0] w_slot;
    logic [7:0] w_byte;

    pcld_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .i_tick(s_axis_tuser), .i_out_free(w_free), .i_status(w_status),
        .o_ready(s_axis_tready), .o_cmd(w_cmd)
    );

    pcld_dp #(.SESSIONS(SESSIONS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_ip(s_axis_tdata[31:0]), .i_port(s_axis_tdata[47:32]),
        .i_byte(s_axis_tdata[55:48]), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_out_ready(m_axis_tready), .o_status(w_status),
        .o_out_free(w_free), .o_out_valid(m_axis_tvalid), .o_kind(m_axis_tuser),
        .o_slot(w_slot), .o_byte(w_byte), .o_end(w_end), .o_cut(w_cut),
        .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'd0, w_cut, w_end, w_byte, w_slot};
endmodule
`default_nettype wire

// File: rtl/pcld_ctrl.sv
// controller for the deframer: accepts beats and sequences expiry scans
// depends on pcld_pkg
`default_nettype none
module pcld_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_tick,
    input  wire logic                i_out_free,
    input  wire pcld_pkg::t_status   i_status,
    output logic                     o_ready,
    output pcld_pkg::t_cmd           o_cmd
);
    pcld_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pcld_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcld_pkg::ST_IDLE: begin
                if (i_valid && i_out_free && i_tick && i_status.scan_due)
                    n_state = pcld_pkg::ST_SCAN;
            end
            pcld_pkg::ST_SCAN: begin
                if (i_out_free && i_status.scan_done) n_state = pcld_pkg::ST_FLUSH;
            end
            pcld_pkg::ST_FLUSH: begin
                if (i_out_free) n_state = pcld_pkg::ST_IDLE;
            end
            default: n_state = pcld_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd = '0;
        case (r_state)
            pcld_pkg::ST_IDLE: begin
                o_ready = i_out_free;
                o_cmd.take_byte = i_valid && i_out_free && !i_tick;
                o_cmd.take_tick = i_valid && i_out_free && i_tick;
                o_cmd.scan_start = o_cmd.take_tick;
            end
            pcld_pkg::ST_SCAN: o_cmd.scan_step = i_out_free;
            pcld_pkg::ST_FLUSH: o_cmd.flush = i_out_free;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/pcld_dp.sv
// datapath for the deframer: session table, time, scan and result register
// depends on pcld_pkg
`default_nettype none
module pcld_dp #(
    parameter int SESSIONS = pcld_pkg::SESSIONS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pcld_pkg::t_cmd    i_cmd,
    input  wire logic [31:0]       i_ip,
    input  wire logic [15:0]       i_port,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_out_ready,
    output pcld_pkg::t_status      o_status,
    output logic                   o_out_free,
    output logic                   o_out_valid,
    output logic [1:0]             o_kind,
    output logic [3:0]             o_slot,
    output logic [7:0]             o_byte,
    output logic                   o_end,
    output logic                   o_cut,
    output logic                   o_last
);
    localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int CW = $clog2(((SESSIONS > pcld_pkg::MAX_EXPIRE) ? SESSIONS
                                : pcld_pkg::MAX_EXPIRE) + 1);

    logic [SESSIONS-1:0] r_valid;
    logic [31:0] r_ip [SESSIONS];
    logic [15:0] r_port [SESSIONS];
    logic [1:0] r_phase [SESSIONS];
    logic [15:0] r_rem [SESSIONS];
    logic [31:0] r_act [SESSIONS];
    logic [31:0] r_time;
    logic [15:0] r_count;
    logic [15:0] r_timeout, r_interval;
    logic [SW-1:0] r_idx;
    logic [CW-1:0] r_nexp;
    // held expiry waiting for a later one to decide last_of_run
    logic r_hold;
    logic [SW-1:0] r_hslot;
    logic r_hcut;

    logic r_ov;
    logic [1:0] r_kind;
    logic [3:0] r_slot;
    logic [7:0] r_ob;
    logic r_oe, r_oc, r_ol;

    assign o_out_free = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_kind = r_kind;
    assign o_slot = r_slot;
    assign o_byte = r_ob;
    assign o_end = r_oe;
    assign o_cut = r_oc;
    assign o_last = r_ol;

    logic [15:0] lim, cnt_inc;
    assign lim = (r_interval == 16'd0) ? 16'd1 : r_interval;
    assign cnt_inc = r_count + 16'd1;
    assign o_status.scan_due = (cnt_inc >= lim);
    assign o_status.scan_done = (r_idx == SW'(SESSIONS - 1));

    // parallel slot match
    logic hit_f, free_f;
    logic [SW-1:0] hit_s, free_s, sel;
    always_comb begin
        hit_f = 1'b0; free_f = 1'b0; hit_s = '0; free_s = '0;
        for (int s = SESSIONS - 1; s >= 0; s--) begin
            if (r_valid[s] && r_ip[s] == i_ip && r_port[s] == i_port) begin
                hit_f = 1'b1; hit_s = SW'(s);
            end
            if (!r_valid[s]) begin
                free_f = 1'b1; free_s = SW'(s);
            end
        end
        sel = hit_f ? hit_s : free_s;
    end

    logic [1:0] cur_ph;
    logic [15:0] cur_rem, low_rem, dec_rem;
    assign cur_ph = hit_f ? r_phase[sel] : pcld_pkg::PH_HIGH;
    assign cur_rem = hit_f ? r_rem[sel] : 16'd0;
    assign low_rem = {cur_rem[15:8], i_byte};
    assign dec_rem = cur_rem - 16'd1;

    // scan test on slot r_idx
    logic exp_now, exp_cut;
    logic [31:0] age;
    assign age = r_time - r_act[r_idx];
    assign exp_now = i_cmd.scan_step && r_valid[r_idx] && (age > {16'd0, r_timeout})
                     && (r_nexp < CW'(pcld_pkg::MAX_EXPIRE));
    assign exp_cut = (r_phase[r_idx] == pcld_pkg::PH_LOW) ||
                     (r_phase[r_idx] == pcld_pkg::PH_PAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_time <= '0;
            r_count <= '0;
            r_timeout <= pcld_pkg::TIMEOUT_RST;
            r_interval <= pcld_pkg::INTERVAL_RST;
            r_ov <= 1'b0;
            r_hold <= 1'b0;
            r_idx <= '0;
            r_nexp <= '0;
            for (int s = 0; s < SESSIONS; s++) begin
                r_phase[s] <= pcld_pkg::PH_HIGH;
                r_rem[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pcld_pkg::REG_TIMEOUT) r_timeout <= i_cfg_data;
                else r_interval <= i_cfg_data;
            end
            if (r_ov && i_out_ready) r_ov <= 1'b0;

            if (i_cmd.take_tick) begin
                r_time <= r_time + 32'd1;
                r_count <= o_status.scan_due ? 16'd0 : cnt_inc;
                r_idx <= '0;
                r_nexp <= '0;
                r_hold <= 1'b0;
            end

            if (i_cmd.take_byte) begin
                if (!hit_f && !free_f) begin
                    r_ov <= 1'b1; r_kind <= pcld_pkg::KIND_DROP; r_slot <= '0;
                    r_ob <= i_byte; r_oe <= 1'b0; r_oc <= 1'b0; r_ol <= 1'b1;
                end else begin
                    r_valid[sel] <= 1'b1;
                    r_ip[sel] <= i_ip;
                    r_port[sel] <= i_port;
                    r_act[sel] <= r_time;
                    case (cur_ph)
                        pcld_pkg::PH_LOW: begin
                            r_rem[sel] <= low_rem;
                            if (low_rem == 16'd0) begin
                                r_phase[sel] <= pcld_pkg::PH_HIGH;
                                r_ov <= 1'b1; r_kind <= pcld_pkg::KIND_EMPTY;
                                r_slot <= 4'(sel); r_ob <= '0; r_oe <= 1'b1;
                                r_oc <= 1'b0; r_ol <= 1'b1;
                            end else r_phase[sel] <= pcld_pkg::PH_PAY;
                        end
                        pcld_pkg::PH_PAY: begin
                            r_rem[sel] <= dec_rem;
                            if (dec_rem == 16'd0) r_phase[sel] <= pcld_pkg::PH_HIGH;
                            r_ov <= 1'b1; r_kind <= pcld_pkg::KIND_PAYLOAD;
                            r_slot <= 4'(sel); r_ob <= i_byte;
                            r_oe <= (dec_rem == 16'd0); r_oc <= 1'b0; r_ol <= 1'b1;
                        end
                        default: begin
                            r_rem[sel] <= {i_byte, 8'd0};
                            r_phase[sel] <= pcld_pkg::PH_LOW;
                        end
                    endcase
                end
            end

            if (i_cmd.scan_step) begin
                r_idx <= r_idx + SW'(1);
                if (exp_now) begin
                    r_valid[r_idx] <= 1'b0;
                    r_phase[r_idx] <= pcld_pkg::PH_HIGH;
                    r_rem[r_idx] <= '0;
                    r_nexp <= r_nexp + CW'(1);
                    r_hold <= 1'b1;
                    r_hslot <= r_idx;
                    r_hcut <= exp_cut;
                    if (r_hold) begin
                        r_ov <= 1'b1; r_kind <= pcld_pkg::KIND_EXPIRED;
                        r_slot <= 4'(r_hslot); r_ob <= '0; r_oe <= 1'b0;
                        r_oc <= r_hcut; r_ol <= 1'b0;
                    end
                end
            end

            // held expiry goes out as the final beat of the tick
            if (i_cmd.flush && r_hold) begin
                r_hold <= 1'b0;
                r_ov <= 1'b1; r_kind <= pcld_pkg::KIND_EXPIRED;
                r_slot <= 4'(r_hslot); r_ob <= '0; r_oe <= 1'b0;
                r_oc <= r_hcut; r_ol <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(i_cmd.take_byte && i_cmd.take_tick))
                else $error("byte and tick taken together");
        end
    end

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_byte || i_cmd.take_tick) |-> o_out_free)
        else $error("beat taken with output full");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.scan_step && (i_cmd.take_byte || i_cmd.take_tick)))
        else $error("scan overlaps a beat");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_byte && !hit_f && !free_f) |-> (&r_valid))
        else $error("drop with free slot");
endmodule
`default_nettype wire
